[sv/rwd_pkg.sv]
// Shared types and constants of the relative weekday date resolver.
`timescale 1ns / 1ps

package rwd_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_PAST_END   = 2'd1;
  localparam logic [1:0] ST_YEAR_RANGE = 2'd2;

  // Special input codes.
  localparam logic [2:0] WD_LAST  = 3'd7;
  localparam logic [2:0] NTH_LAST = 3'd0;

  // The month sum is biased by a whole number of years so it stays positive.
  localparam int MON_BIAS_YEARS = 5462;
  localparam int MON_BIAS       = 12 * MON_BIAS_YEARS;
  // Shift from a signed year to the unsigned year count used for day sums.
  localparam int YEAR_SHIFT     = 32799;
  localparam int BY_OFFSET      = YEAR_SHIFT - MON_BIAS_YEARS;

  // Reciprocal constants for division by 3 and by 25.
  localparam int RECIP3         = 43691;
  localparam int RECIP3_SHIFT   = 17;
  localparam int RECIP25        = 20972;
  localparam int RECIP25_SHIFT  = 19;

  // Normalized year and month.
  typedef struct packed {
    logic [16:0] ny;    // signed year after the offset
    logic [16:0] by;    // unsigned year count, valid when in range
    logic [3:0]  nm;
    logic [2:0]  wd;
    logic [2:0]  nth;
    logic        oor;
  } nrm_t;

  // Year facts: leap flag and day count of the year start, reduced later.
  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  nm;
    logic [2:0]  wd;
    logic [2:0]  nth;
    logic        oor;
    logic        leap;
    logic [16:0] s;     // congruent modulo 7 to the days before the year
  } yr_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        leap;
    logic [1:0]  status;
  } res_t;

endpackage

[sv/rwd_if.sv]
// Channel interfaces of the relative weekday date resolver.
`timescale 1ns / 1ps

interface rwd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] year;
  logic [3:0]         month;
  logic signed [16:0] month_offset;
  logic [2:0]         weekday;
  logic [2:0]         nth;

  modport source (output valid, year, month, month_offset, weekday, nth, input ready);
  modport sink   (input valid, year, month, month_offset, weekday, nth, output ready);
endinterface

interface rwd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_year;
  logic [3:0]         out_month;
  logic [4:0]         out_day;
  logic               leap_year;
  logic [1:0]         status;

  modport source (output valid, out_year, out_month, out_day, leap_year, status,
                  input ready);
  modport sink   (input valid, out_year, out_month, out_day, leap_year, status,
                  output ready);
endinterface

[sv/rwd_month_norm.sv]
// Stages one to three: month offset addition and split into year and month.
`timescale 1ns / 1ps

module rwd_month_norm
  import rwd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic signed [15:0] year,
  input  logic [3:0]         month,
  input  logic signed [16:0] month_offset,
  input  logic [2:0]         weekday,
  input  logic [2:0]         nth,
  output logic               nrm_valid,
  output nrm_t               nrm
);

  // Stage one: biased month count.
  logic        v1_r;
  logic [17:0] u_r, u_nxt;
  logic [15:0] y1_r;
  logic [2:0]  wd1_r, nth1_r;
  logic [18:0] sum19;

  // Stage two: count of months divided by four, times the reciprocal of 3.
  logic        v2_r;
  logic [32:0] prod_r, prod_nxt;
  logic [15:0] q4_r;
  logic [1:0]  ulo_r;
  logic [15:0] y2_r;
  logic [2:0]  wd2_r, nth2_r;

  // Stage three.
  logic        v3_r;
  nrm_t        nrm_r, nrm_nxt;
  logic [13:0] q;
  logic [15:0] rem3;
  logic [16:0] ny_c;

  assign sum19 = {{2{month_offset[16]}}, month_offset} + {15'd0, month}
               + 19'(MON_BIAS - 1);
  assign u_nxt = sum19[17:0];

  assign prod_nxt = {17'd0, u_r[17:2]} * 33'(RECIP3);

  assign q    = prod_r[RECIP3_SHIFT+13:RECIP3_SHIFT];
  assign rem3 = q4_r - 16'({2'd0, q} * 16'd3);
  assign ny_c = {y2_r[15], y2_r} + {3'd0, q} - 17'(MON_BIAS_YEARS);

  always_comb begin
    nrm_nxt.ny  = ny_c;
    nrm_nxt.by  = {y2_r[15], y2_r} + {3'd0, q} + 17'(BY_OFFSET);
    nrm_nxt.nm  = {rem3[1:0], ulo_r} + 4'd1;
    nrm_nxt.wd  = wd2_r;
    nrm_nxt.nth = nth2_r;
    // A 17-bit year fits 16 bits only when its top two bits agree.
    nrm_nxt.oor = ny_c[16] ^ ny_c[15];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u_r    <= u_nxt;
      y1_r   <= year;
      wd1_r  <= weekday;
      nth1_r <= nth;
      prod_r <= prod_nxt;
      q4_r   <= u_r[17:2];
      ulo_r  <= u_r[1:0];
      y2_r   <= y1_r;
      wd2_r  <= wd1_r;
      nth2_r <= nth1_r;
      nrm_r  <= nrm_nxt;
    end
  end

  assign nrm_valid = v3_r;
  assign nrm       = nrm_r;

endmodule

[sv/rwd_year_calc.sv]
// Stages four and five: leap year flag and day count of the year start.
`timescale 1ns / 1ps

module rwd_year_calc
  import rwd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic nrm_valid,
  input  nrm_t nrm,
  output logic yr_valid,
  output yr_t  yr
);

  logic        v4_r;
  nrm_t        n4_r;
  logic [29:0] prodc_r, prodc_nxt;

  logic        v5_r;
  yr_t         yr_r, yr_nxt;
  logic [14:0] w;
  logic [10:0] c;
  logic [14:0] r25;
  logic [17:0] s18;

  // Stage four: quarter of the year count times the reciprocal of 25.
  assign prodc_nxt = {15'd0, nrm.by[16:2]} * 30'(RECIP25);

  // Stage five: c is the year count divided by 100.
  assign w   = n4_r.by[16:2];
  assign c   = prodc_r[RECIP25_SHIFT+10:RECIP25_SHIFT];
  assign r25 = w - 15'({4'd0, c} * 15'd25);
  // 365 is 1 modulo 7, so the year count itself stands for the plain days.
  assign s18 = {1'b0, n4_r.by} + {3'd0, w} + {9'd0, c[10:2]} - {7'd0, c};

  always_comb begin
    yr_nxt.year = n4_r.ny[15:0];
    yr_nxt.nm   = n4_r.nm;
    yr_nxt.wd   = n4_r.wd;
    yr_nxt.nth  = n4_r.nth;
    yr_nxt.oor  = n4_r.oor;
    // The following year is a leap year when it is divisible by 4, except
    // centuries that are not divisible by 400.
    yr_nxt.leap = (n4_r.by[1:0] == 2'b11)
                && ((r25[4:0] != 5'd24) || (c[1:0] == 2'b11));
    yr_nxt.s    = s18[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v4_r <= nrm_valid;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n4_r    <= nrm;
      prodc_r <= prodc_nxt;
      yr_r    <= yr_nxt;
    end
  end

  assign yr_valid = v5_r;
  assign yr       = yr_r;

endmodule

[sv/rwd_day_pick.sv]
// Stages six and seven: month weekdays and selection of the day.
`timescale 1ns / 1ps

module rwd_day_pick
  import rwd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic yr_valid,
  input  yr_t  yr,
  output logic res_valid,
  output res_t res
);

  function automatic logic [2:0] mod7_small(input logic [3:0] v);
    mod7_small = (v >= 4'd7) ? 3'(v - 4'd7) : v[2:0];
  endfunction

  // Octal digits each count as themselves modulo 7.
  function automatic logic [2:0] mod7_wide(input logic [16:0] s);
    logic [5:0] dsum;
    logic [3:0] fold;
    dsum = {3'd0, s[2:0]} + {3'd0, s[5:3]} + {3'd0, s[8:6]} + {3'd0, s[11:9]}
         + {3'd0, s[14:12]} + {4'd0, s[16:15]};
    fold = {1'b0, dsum[2:0]} + {1'b0, dsum[5:3]};
    mod7_wide = mod7_small(fold);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] nm, input logic leap);
    unique case (nm)
      4'd2:                      month_days = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   month_days = 5'd30;
      default:                   month_days = 5'd31;
    endcase
  endfunction

  // Days before the first of the month plus one, modulo 7.
  function automatic logic [2:0] first_off(input logic [3:0] nm, input logic leap);
    logic [2:0] base;
    unique case (nm)
      4'd1:    base = 3'd1;
      4'd2:    base = 3'd4;
      4'd3:    base = 3'd4;
      4'd4:    base = 3'd0;
      4'd5:    base = 3'd2;
      4'd6:    base = 3'd5;
      4'd7:    base = 3'd0;
      4'd8:    base = 3'd3;
      4'd9:    base = 3'd6;
      4'd10:   base = 3'd1;
      4'd11:   base = 3'd4;
      4'd12:   base = 3'd6;
      default: base = 3'd0;
    endcase
    if (leap && (nm > 4'd2)) begin
      first_off = (base == 3'd6) ? 3'd0 : base + 3'd1;
    end else begin
      first_off = base;
    end
  endfunction

  // Stage six.
  logic       v6_r;
  yr_t        y6_r;
  logic [2:0] fdow_r, fdow_nxt;
  logic [2:0] ldow_r, ldow_nxt;
  logic [4:0] dim_r, dim_nxt;
  logic [2:0] dim_adj;

  // Stage seven.
  logic       v7_r;
  res_t       res_r, res_nxt;
  logic [2:0] x_last, x_first;
  logic [4:0] day_last;
  logic [5:0] day_nth;
  logic       past;

  assign dim_nxt  = month_days(yr.nm, yr.leap);
  assign fdow_nxt = mod7_small({1'b0, mod7_wide(yr.s)} + {1'b0, first_off(yr.nm, yr.leap)});
  // Month length minus one, modulo 7.
  assign dim_adj  = (dim_nxt == 5'd28) ? 3'd6 : 3'(dim_nxt - 5'd29);
  assign ldow_nxt = mod7_small({1'b0, fdow_nxt} + {1'b0, dim_adj});

  assign x_last   = mod7_small({1'b0, ldow_r} + 4'd7 - {1'b0, y6_r.wd});
  assign x_first  = mod7_small({1'b0, y6_r.wd} + 4'd7 - {1'b0, fdow_r});
  assign day_last = dim_r - {2'd0, x_last};
  assign day_nth  = 6'd1 + (({3'd0, y6_r.nth} - 6'd1) * 6'd7) + {3'd0, x_first};
  assign past     = day_nth > {1'b0, dim_r};

  always_comb begin
    res_nxt.year   = y6_r.year;
    res_nxt.month  = y6_r.nm;
    res_nxt.leap   = y6_r.leap && !y6_r.oor;
    res_nxt.day    = 5'd0;
    res_nxt.status = ST_OK;
    priority if (y6_r.oor) begin
      res_nxt.status = ST_YEAR_RANGE;
    end else if (y6_r.wd == WD_LAST) begin
      res_nxt.day = dim_r;
    end else if (y6_r.nth == NTH_LAST) begin
      res_nxt.day = day_last;
    end else if (past) begin
      res_nxt.status = ST_PAST_END;
    end else begin
      res_nxt.day = day_nth[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (adv) begin
      v6_r <= yr_valid;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y6_r   <= yr;
      fdow_r <= fdow_nxt;
      ldow_r <= ldow_nxt;
      dim_r  <= dim_nxt;
      res_r  <= res_nxt;
    end
  end

  assign res_valid = v7_r;
  assign res       = res_r;

endmodule

[sv/relative_weekday_date_resolver_top.sv]
// Top level of the relative weekday date resolver pipeline.
//
//  Channel   Role      Carries
//  in_chan   sink      year, month, month_offset, weekday, nth
//  out_chan  source    out_year, out_month, out_day, leap_year, status
//
// One transaction per cycle while the output is not stalled; each passes through
// the seven register stages (two multiplier stages among them).
// All stages advance together whenever the output register is empty or taken,
// so a stall freezes the whole pipeline and nothing is dropped or repeated.
// Synchronous active-low reset clears the stage valid bits only.
`timescale 1ns / 1ps

module relative_weekday_date_resolver_top
  import rwd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  rwd_in_if.sink    in_chan,
  rwd_out_if.source out_chan
);

  logic adv;
  logic nrm_valid, yr_valid, res_valid;
  nrm_t nrm;
  yr_t  yr;
  res_t res;

  assign adv           = !res_valid || out_chan.ready;
  assign in_chan.ready = adv;

  rwd_month_norm u_month_norm (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_valid     (in_chan.valid),
    .year         (in_chan.year),
    .month        (in_chan.month),
    .month_offset (in_chan.month_offset),
    .weekday      (in_chan.weekday),
    .nth          (in_chan.nth),
    .nrm_valid    (nrm_valid),
    .nrm          (nrm)
  );

  rwd_year_calc u_year_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .nrm_valid (nrm_valid),
    .nrm       (nrm),
    .yr_valid  (yr_valid),
    .yr        (yr)
  );

  rwd_day_pick u_day_pick (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .yr_valid  (yr_valid),
    .yr        (yr),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_chan.valid     = res_valid;
  assign out_chan.out_year  = res.year;
  assign out_chan.out_month = res.month;
  assign out_chan.out_day   = res.day;
  assign out_chan.leap_year = res.leap;
  assign out_chan.status    = res.status;

  // A year out of range carries no day and no leap flag.
  a_range_clears_day : assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status == ST_YEAR_RANGE))
      |-> ((out_chan.out_day == 5'd0) && !out_chan.leap_year))
    else $error("year out of range with nonzero day or leap flag");

  // A good result always names a real day of a real month.
  a_ok_day_real : assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status == ST_OK))
      |-> ((out_chan.out_day != 5'd0) && (out_chan.out_month != 4'd0)
           && (out_chan.out_month <= 4'd12)))
    else $error("good result without a valid day or month");

  // Nothing comes out in the cycle after reset.
  a_reset_empty : assert property (@(posedge clk)
    $past(!rst_n) |-> !out_chan.valid)
    else $error("output valid right after reset");

endmodule
